### rtl/b64w_pkg.sv
package b64w_pkg;

  // Characters on one output line before CR LF is due
  localparam int LINE_CHARS = 76;
  localparam int COL_W      = $clog2(LINE_CHARS + 1);

  // Group queue between the gatherer and the emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [6:0] CH_CR  = 7'd13;
  localparam logic [6:0] CH_LF  = 7'd10;
  localparam logic [6:0] CH_PAD = 7'd61;

  localparam logic [6:0] CH_UPPER_A = 7'd65;
  localparam logic [6:0] CH_LOWER_A = 7'd97;
  localparam logic [6:0] CH_DIGIT_0 = 7'd48;
  localparam logic [6:0] CH_PLUS    = 7'd43;
  localparam logic [6:0] CH_SLASH   = 7'd47;

  // One group of up to three bytes, MSB first, ready to encode
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  held;   // bytes that were buffered before the closing byte
    logic        last;   // group closes the stream
  } grp_t;

  // Queue status seen by the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    PH_DATA,
    PH_LF
  } emit_ph_t;

  // Standard alphabet: A-Z a-z 0-9 + /
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = CH_UPPER_A + {1'b0, idx};
    end else if (idx < 6'd52) begin
      ch = CH_LOWER_A + {1'b0, idx} - 7'd26;
    end else if (idx < 6'd62) begin
      ch = CH_DIGIT_0 + {1'b0, idx} - 7'd52;
    end else if (idx == 6'd62) begin
      ch = CH_PLUS;
    end else begin
      ch = CH_SLASH;
    end
    return ch;
  endfunction

endpackage

### rtl/base64_encoder_line_wrap_unit.sv
// Streaming Base64 encoder with optional 76-column line wrapping. Push one raw
// byte per word (in_last on the final byte of a stream); pop one ASCII
// character per word. Every three bytes give four alphabet characters; the last
// byte closes the group, padded with '=' when short. With cfg wrap enabled (reset
// value 1), CR LF is put out before a character once a full line stands, never
// after the final character; the line restarts at each new stream. Rate: a
// byte is taken every cycle while the two-entry group queue has room, and the
// output side emits one character per cycle while groups are queued and the
// consumer keeps popping, through the single-character output register; a line
// break adds CR and LF words to a group's four. A buffered byte produces nothing;
// the output word marked out_run_last closes the characters of one group, and
// out_stream_end marks the final character of the stream. Change the wrap
// setting only while no words are in flight.
module base64_encoder_line_wrap_unit (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  // byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  // character output
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_run_last,
  output logic       out_stream_end
);

  logic              wrap_en_r;
  b64w_pkg::q_stat_t q_stat;
  b64w_pkg::grp_t    q_wdata;
  b64w_pkg::grp_t    q_head;
  logic              q_push;
  logic              q_pop;
  logic              q_vld;

  // wrap enable register, reset to wrapping on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      wrap_en_r <= cfg_wr_data;
    end
  end

  // input side stalls whenever the group queue is full, even for a byte
  // that would only be buffered
  assign full = q_stat.full;

  // front: gathers bytes into groups of three
  b64w_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_byte (in_byte),
    .in_last (in_last),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // short group queue decoupling gatherer and emitter
  b64w_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_stat  (q_stat),
    .q_vld   (q_vld),
    .q_head  (q_head)
  );

  // back: one character per cycle while popped, line breaks, output register
  b64w_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wrap_en        (wrap_en_r),
    .q_vld          (q_vld),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_char       (out_char),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

### rtl/b64w_front.sv
module b64w_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  b64w_pkg::q_stat_t q_stat,
  output logic              q_push,
  output b64w_pkg::grp_t    q_wdata
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;

  assign accept = push && !q_stat.full;

  always_comb begin
    pend_nxt        = pend_r;
    cnt_nxt         = cnt_r;
    q_push          = 1'b0;
    q_wdata.last    = in_last;
    q_wdata.held    = cnt_r;
    case (cnt_r)
      2'd0:    q_wdata.bits = {in_byte, 16'h0000};
      2'd1:    q_wdata.bits = {pend_r[7:0], in_byte, 8'h00};
      default: q_wdata.bits = {pend_r, in_byte};
    endcase
    if (accept) begin
      if (cnt_r < 2'd2 && !in_last) begin
        pend_nxt = {pend_r[7:0], in_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end else begin
        q_push   = 1'b1;
        cnt_nxt  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

### rtl/b64w_queue.sv
module b64w_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  b64w_pkg::grp_t    q_wdata,
  input  logic              q_pop,
  output b64w_pkg::q_stat_t q_stat,
  output logic              q_vld,
  output b64w_pkg::grp_t    q_head
);

  b64w_pkg::grp_t mem_r [b64w_pkg::QUEUE_DEPTH];

  logic [b64w_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64w_pkg::QCNT_W-1:0] cnt_r;

  localparam logic [b64w_pkg::QPTR_W-1:0] PTR_LAST =
    b64w_pkg::QPTR_W'(b64w_pkg::QUEUE_DEPTH - 1);

  assign q_stat.full  = (cnt_r == b64w_pkg::QCNT_W'(b64w_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_vld        = !q_stat.empty;
  assign q_head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !q_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

### rtl/b64w_back.sv
module b64w_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wrap_en,
  input  logic           q_vld,
  input  b64w_pkg::grp_t q_head,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output logic [6:0]     out_char,
  output logic           out_run_last,
  output logic           out_stream_end
);

  localparam logic [b64w_pkg::COL_W-1:0] COL_MAX =
    b64w_pkg::COL_W'(b64w_pkg::LINE_CHARS);

  b64w_pkg::emit_ph_t ph_r, ph_nxt;
  logic [1:0]                 idx_r, idx_nxt;
  logic [b64w_pkg::COL_W-1:0] col_r, col_nxt;
  logic                       vld_r, vld_nxt;
  logic [6:0]                 char_r, char_nxt;
  logic                       run_last_r, run_last_nxt;
  logic                       end_r, end_nxt;
  logic                       adv;
  logic [5:0]                 sext;
  logic [6:0]                 dchar;

  // sextet picked by character position
  always_comb begin
    case (idx_r)
      2'd0:    sext = q_head.bits[23:18];
      2'd1:    sext = q_head.bits[17:12];
      2'd2:    sext = q_head.bits[11:6];
      default: sext = q_head.bits[5:0];
    endcase
    dchar = ({1'b0, idx_r} < ({1'b0, q_head.held} + 3'd2)) ?
            b64w_pkg::b64_char(sext) : b64w_pkg::CH_PAD;
  end

  assign adv = q_vld && (!vld_r || pop);

  always_comb begin
    ph_nxt       = ph_r;
    idx_nxt      = idx_r;
    col_nxt      = col_r;
    vld_nxt      = vld_r && !pop;
    char_nxt     = char_r;
    run_last_nxt = run_last_r;
    end_nxt      = end_r;
    q_pop        = 1'b0;
    if (adv) begin
      vld_nxt      = 1'b1;
      run_last_nxt = 1'b0;
      end_nxt      = 1'b0;
      unique case (ph_r)
        b64w_pkg::PH_DATA: begin
          if (wrap_en && col_r >= COL_MAX) begin
            char_nxt = b64w_pkg::CH_CR;
            ph_nxt   = b64w_pkg::PH_LF;
          end else begin
            char_nxt = dchar;
            col_nxt  = (col_r < COL_MAX) ? col_r + 1'b1 : col_r;
            if (idx_r == 2'd3) begin
              q_pop        = 1'b1;
              idx_nxt      = 2'd0;
              run_last_nxt = 1'b1;
              end_nxt      = q_head.last;
              if (q_head.last) begin
                col_nxt = '0;
              end
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
        b64w_pkg::PH_LF: begin
          char_nxt = b64w_pkg::CH_LF;
          col_nxt  = '0;
          ph_nxt   = b64w_pkg::PH_DATA;
        end
        default: begin
          ph_nxt = b64w_pkg::PH_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= b64w_pkg::PH_DATA;
      idx_r <= 2'd0;
      col_r <= '0;
      vld_r <= 1'b0;
    end else begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
      col_r <= col_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    run_last_r <= run_last_nxt;
    end_r      <= end_nxt;
  end

  assign empty          = !vld_r;
  assign out_char       = char_r;
  assign out_run_last   = run_last_r;
  assign out_stream_end = end_r;

  // mid-group state only exists while its group is still queued
  a_midgrp_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0 || ph_r == b64w_pkg::PH_LF) |-> q_vld)
    else $error("emitter mid-group with no queued group");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_MAX)
    else $error("line column past line length");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && end_r) |-> run_last_r)
    else $error("stream end on a word that is not the group's last");

  a_lf_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ph_r == b64w_pkg::PH_DATA && ph_nxt == b64w_pkg::PH_LF)
      |=> (vld_r && char_r == b64w_pkg::CH_CR))
    else $error("CR not presented when LF becomes due");

endmodule
